// ===== hw/rtl/reb_pkg.sv =====
// ----------------------------------------------------------------------------
// reb_pkg
// Shared types, constants and rounding helper for the rotary embedding
// backward block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package reb_pkg;

  localparam int MAX_POSITIONS = 1024;
  localparam int MAX_PAIRS     = 64;

  localparam int POS_W    = 10;
  localparam int PAIR_W   = 6;
  localparam int DATA_W   = 16;
  localparam int CFG_W    = 10;
  localparam int COUNT_W  = 7;
  localparam int ROW_W    = POS_W + 1;
  localparam int TAB_AW   = $clog2(MAX_POSITIONS) + $clog2(MAX_PAIRS);
  localparam int TAB_DEPTH = MAX_POSITIONS * MAX_PAIRS;
  localparam int PROD_W   = 2 * DATA_W;
  localparam int SUM_W    = PROD_W + 1;
  localparam int FRAC_W   = 14;
  localparam int Q_W      = SUM_W + 1 - FRAC_W;

  localparam logic [COUNT_W-1:0] ROTARY_PAIRS_RST = COUNT_W'(MAX_PAIRS);

  typedef enum logic {
    ACT_LOAD   = 1'b0,
    ACT_ROTATE = 1'b1
  } reb_action_e;

  typedef enum logic {
    REG_POSITION_OFFSET = 1'b0,
    REG_ROTARY_PAIRS    = 1'b1
  } reb_reg_e;

  // Per-item control that travels alongside the data.
  typedef struct packed {
    logic range_err;
    logic pass;
  } reb_ctrl_t;

  typedef struct packed {
    logic [DATA_W-1:0] value;
    logic              sat;
  } reb_rnd_t;

  // Round at bit 14 with halves toward +infinity, then clip to 16 bits.
  function automatic reb_rnd_t round_sat(input logic signed [SUM_W-1:0] v);
    logic signed [SUM_W:0] t;
    logic [Q_W-1:0]        q;
    reb_rnd_t              r;
    t = $signed({v[SUM_W-1], v}) + $signed((SUM_W+1)'(1 << (FRAC_W - 1)));
    q = t[SUM_W:FRAC_W];
    if ((q[Q_W-1:DATA_W-1] == '0) || (q[Q_W-1:DATA_W-1] == '1)) begin
      r.value = q[DATA_W-1:0];
      r.sat   = 1'b0;
    end else begin
      r.value = q[Q_W-1] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
      r.sat   = 1'b1;
    end
    return r;
  endfunction

endpackage

// ===== hw/rtl/reb_rotate_pipe.sv =====
// ----------------------------------------------------------------------------
// reb_rotate_pipe
// Three-stage rotation datapath: products, sums, then rounding with the
// pass-through and range-error selection into the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module reb_rotate_pipe (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [reb_pkg::DATA_W-1:0] in_x_i,
  input  logic [reb_pkg::DATA_W-1:0] in_y_i,
  input  logic [reb_pkg::DATA_W-1:0] in_cos_i,
  input  logic [reb_pkg::DATA_W-1:0] in_sin_i,
  input  reb_pkg::reb_ctrl_t         in_ctrl_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [reb_pkg::DATA_W-1:0] out_first_o,
  output logic [reb_pkg::DATA_W-1:0] out_second_o,
  output logic                      saturated_o,
  output logic                      range_error_o
);
  import reb_pkg::*;

  logic rdy2, rdy3, rdy4;
  logic v2_q, v3_q, v4_q;

  // Stage 2: four products.
  logic signed [PROD_W-1:0] xc_q, ys_q, yc_q, xs_q;
  logic [DATA_W-1:0]        x2_q, y2_q;
  reb_ctrl_t                ctrl2_q;

  // Stage 3: the two sums.
  logic signed [SUM_W-1:0]  sum0_q, sum1_q;
  logic [DATA_W-1:0]        x3_q, y3_q;
  reb_ctrl_t                ctrl3_q;

  // Stage 4: output register.
  logic [DATA_W-1:0]        first_q, second_q;
  logic                     sat_q, err_q;

  reb_rnd_t                 rnd0, rnd1;
  logic [DATA_W-1:0]        first_d, second_d;
  logic                     sat_d;

  assign rdy4       = !v4_q || out_ready_i;
  assign rdy3       = !v3_q || rdy4;
  assign rdy2       = !v2_q || rdy3;
  assign in_ready_o = rdy2;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (rdy2) begin
        v2_q <= in_valid_i;
      end
      if (rdy3) begin
        v3_q <= v2_q;
      end
      if (rdy4) begin
        v4_q <= v3_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy2 && in_valid_i) begin
      xc_q    <= $signed(in_x_i) * $signed(in_cos_i);
      ys_q    <= $signed(in_y_i) * $signed(in_sin_i);
      yc_q    <= $signed(in_y_i) * $signed(in_cos_i);
      xs_q    <= $signed(in_x_i) * $signed(in_sin_i);
      x2_q    <= in_x_i;
      y2_q    <= in_y_i;
      ctrl2_q <= in_ctrl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy3 && v2_q) begin
      sum0_q  <= SUM_W'(xc_q) + SUM_W'(ys_q);
      sum1_q  <= SUM_W'(yc_q) - SUM_W'(xs_q);
      x3_q    <= x2_q;
      y3_q    <= y2_q;
      ctrl3_q <= ctrl2_q;
    end
  end

  always_comb begin
    rnd0 = round_sat(sum0_q);
    rnd1 = round_sat(sum1_q);
    priority if (ctrl3_q.range_err) begin
      first_d  = '0;
      second_d = '0;
      sat_d    = 1'b0;
    end else if (ctrl3_q.pass) begin
      first_d  = x3_q;
      second_d = y3_q;
      sat_d    = 1'b0;
    end else begin
      first_d  = rnd0.value;
      second_d = rnd1.value;
      sat_d    = rnd0.sat || rnd1.sat;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy4 && v3_q) begin
      first_q  <= first_d;
      second_q <= second_d;
      sat_q    <= sat_d;
      err_q    <= ctrl3_q.range_err;
    end
  end

  assign out_valid_o   = v4_q;
  assign out_first_o   = first_q;
  assign out_second_o  = second_q;
  assign saturated_o   = sat_q;
  assign range_error_o = err_q;

endmodule

// ===== hw/rtl/rotary_embedding_backward_top.sv =====
// ----------------------------------------------------------------------------
// rotary_embedding_backward_top
// A rotate item passes the table-read register, then the product, sum and
// output registers. Throughput: one item per cycle unless the output stalls;
// the table RAM has one write and one read port. Load items write the table at
// acceptance and give no result. Reset clears the pipe valids and the offset, sets
// the pair count to 64; the table is not cleared and holds garbage until loaded.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rotary_embedding_backward_top (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic                       action_i,
  input  logic [reb_pkg::POS_W-1:0]  position_i,
  input  logic [reb_pkg::PAIR_W-1:0] pair_index_i,
  input  logic [reb_pkg::DATA_W-1:0] first_value_i,
  input  logic [reb_pkg::DATA_W-1:0] second_value_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [reb_pkg::DATA_W-1:0] out_first_o,
  output logic [reb_pkg::DATA_W-1:0] out_second_o,
  output logic                       saturated_o,
  output logic                       range_error_o,
  input  logic                       cfg_we_i,
  input  logic                       cfg_index_i,
  input  logic [reb_pkg::CFG_W-1:0]  cfg_data_i
);
  import reb_pkg::*;

  logic [POS_W-1:0]     pos_offset_q;
  logic [COUNT_W-1:0]   rot_pairs_q;

  logic                 in_fire, rot_fire, load_fire;
  logic                 rdy1, pipe_ready;
  logic [ROW_W-1:0]     row_sum;
  logic [TAB_AW-1:0]    rd_addr, wr_addr;
  reb_ctrl_t            ctrl_d;

  logic                 s1_v_q;
  logic [DATA_W-1:0]    x1_q, y1_q;
  reb_ctrl_t            ctrl1_q;
  logic [2*DATA_W-1:0]  entry_q;

  logic [2*DATA_W-1:0]  table_mem [TAB_DEPTH];

  // Config registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_offset_q <= '0;
      rot_pairs_q  <= ROTARY_PAIRS_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_POSITION_OFFSET: pos_offset_q <= cfg_data_i[POS_W-1:0];
        REG_ROTARY_PAIRS:    rot_pairs_q  <= cfg_data_i[COUNT_W-1:0];
        default:             pos_offset_q <= pos_offset_q;
      endcase
    end
  end

  assign rdy1       = !s1_v_q || pipe_ready;
  assign in_ready_o = rdy1;
  assign in_fire    = in_valid_i && rdy1;
  assign rot_fire   = in_fire && (action_i == ACT_ROTATE);
  assign load_fire  = in_fire && (action_i == ACT_LOAD);

  assign row_sum = {1'b0, position_i} + {1'b0, pos_offset_q};
  assign rd_addr = {row_sum[POS_W-1:0], pair_index_i};
  assign wr_addr = {position_i, pair_index_i};

  // A count of zero or above the pair limit rotates every pair.
  always_comb begin
    ctrl_d.range_err = (row_sum >= ROW_W'(MAX_POSITIONS));
    ctrl_d.pass      = (rot_pairs_q != '0) && (rot_pairs_q <= COUNT_W'(MAX_PAIRS)) &&
                       ({1'b0, pair_index_i} >= rot_pairs_q);
  end

  always_ff @(posedge clk_i) begin
    if (load_fire) begin
      table_mem[wr_addr] <= {first_value_i, second_value_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (rot_fire) begin
      entry_q <= table_mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else if (rdy1) begin
      s1_v_q <= rot_fire;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rot_fire) begin
      x1_q    <= first_value_i;
      y1_q    <= second_value_i;
      ctrl1_q <= ctrl_d;
    end
  end

  reb_rotate_pipe u_rotate (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (s1_v_q),
    .in_ready_o    (pipe_ready),
    .in_x_i        (x1_q),
    .in_y_i        (y1_q),
    .in_cos_i      (entry_q[2*DATA_W-1:DATA_W]),
    .in_sin_i      (entry_q[DATA_W-1:0]),
    .in_ctrl_i     (ctrl1_q),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .out_first_o   (out_first_o),
    .out_second_o  (out_second_o),
    .saturated_o   (saturated_o),
    .range_error_o (range_error_o)
  );

`ifndef SYNTH
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && range_error_o |-> (out_first_o == '0) && (out_second_o == '0) &&
      !saturated_o)
    else $error("range error item carries nonzero data");

  a_sat_rail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && saturated_o |->
      (out_first_o == 16'h7fff) || (out_first_o == 16'h8000) ||
      (out_second_o == 16'h7fff) || (out_second_o == 16'h8000))
    else $error("saturated flag without a clipped value");

  a_rot_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rot_fire |=> s1_v_q)
    else $error("accepted rotate item lost at first stage");

  a_load_no_stage: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_fire && !s1_v_q |=> !s1_v_q)
    else $error("load item entered the rotate pipeline");
`endif

endmodule
